>>> rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: types and constants for the quaternion vector rotator
// Request and result payloads, matrix row coefficients and datapath widths.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Field widths
  localparam int unsigned QuatW = 16;           // Q2.14 quaternion component
  localparam int unsigned VecW  = 32;           // Q16.16 vector component
  localparam int unsigned ProdW = 2 * QuatW;    // product of two quaternion terms
  localparam int unsigned MatW  = ProdW + 2;    // matrix entry, Q4.28 plus headroom

  // Vector split into a signed upper half and an unsigned lower half
  localparam int unsigned HalfW = VecW / 2;
  localparam int unsigned PhiW  = MatW + HalfW;       // entry times upper half
  localparam int unsigned PloW  = MatW + HalfW + 1;   // entry times lower half
  localparam int unsigned HiW   = PhiW + 2;           // sum of three upper products
  localparam int unsigned LoW   = PloW + 2;           // sum of three lower products
  localparam int unsigned AccW  = HiW + HalfW + 1;    // full dot product, 2^-44 units

  // Rounding from 2^-44 units down to Q16.16
  localparam int unsigned FracDrop = 28;
  localparam int unsigned RndW     = AccW - FracDrop;

  typedef logic signed [QuatW-1:0] quat_t;
  typedef logic signed [VecW-1:0]  comp_t;
  typedef logic signed [MatW-1:0]  mat_t;

  // Request payload
  typedef struct packed {
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    comp_t vec_x;
    comp_t vec_y;
    comp_t vec_z;
  } req_t;

  // Result payload
  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
  } rsp_t;

  // One row of the rotation matrix
  typedef struct packed {
    mat_t c0;
    mat_t c1;
    mat_t c2;
  } row_t;

  // Vector operand
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

endpackage

>>> rtl/core/qvr_row.sv
// ----------------------------------------------------------------------------
// qvr_row: one matrix row times the vector, rounded and saturated
// Three register stages: split products, row sums, round and clamp.
// ----------------------------------------------------------------------------
module qvr_row (
  input  logic          clk_i,
  input  qvr_pkg::row_t row_i,
  input  qvr_pkg::vec_t vec_i,
  output qvr_pkg::comp_t res_o
);

  localparam int unsigned HalfW = qvr_pkg::HalfW;
  localparam int unsigned VecW  = qvr_pkg::VecW;
  localparam int unsigned RndW  = qvr_pkg::RndW;
  localparam logic signed [qvr_pkg::AccW-1:0] RoundHalf =
    qvr_pkg::AccW'(1) <<< (qvr_pkg::FracDrop - 1);

  qvr_pkg::mat_t              m   [3];
  qvr_pkg::comp_t             v   [3];
  logic signed [HalfW:0]      vl  [3];
  logic signed [HalfW-1:0]    vh  [3];

  logic signed [qvr_pkg::PhiW-1:0] phi_d [3];
  logic signed [qvr_pkg::PhiW-1:0] phi_q [3];
  logic signed [qvr_pkg::PloW-1:0] plo_d [3];
  logic signed [qvr_pkg::PloW-1:0] plo_q [3];

  logic signed [qvr_pkg::HiW-1:0]  hi_d, hi_q;
  logic signed [qvr_pkg::LoW-1:0]  lo_d, lo_q;

  logic signed [qvr_pkg::AccW-1:0] acc;
  logic signed [RndW-1:0]          rnd;
  logic                            fits;
  qvr_pkg::comp_t                  res_d, res_q;

  assign m[0] = row_i.c0;
  assign m[1] = row_i.c1;
  assign m[2] = row_i.c2;
  assign v[0] = vec_i.x;
  assign v[1] = vec_i.y;
  assign v[2] = vec_i.z;

  // Stage A: entry times upper (signed) and lower (unsigned) vector halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vl[i]    = $signed({1'b0, v[i][HalfW-1:0]});
      vh[i]    = v[i][VecW-1:HalfW];
      phi_d[i] = qvr_pkg::PhiW'(m[i]) * qvr_pkg::PhiW'(vh[i]);
      plo_d[i] = qvr_pkg::PloW'(m[i]) * qvr_pkg::PloW'(vl[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      phi_q[i] <= phi_d[i];
      plo_q[i] <= plo_d[i];
    end
  end

  // Stage B: sum the three products of each half
  assign hi_d = qvr_pkg::HiW'(phi_q[0]) + qvr_pkg::HiW'(phi_q[1])
              + qvr_pkg::HiW'(phi_q[2]);
  assign lo_d = qvr_pkg::LoW'(plo_q[0]) + qvr_pkg::LoW'(plo_q[1])
              + qvr_pkg::LoW'(plo_q[2]);

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  // Stage C: recombine, round half up to Q16.16, clamp to 32 bits
  assign acc  = (qvr_pkg::AccW'(hi_q) <<< HalfW) + qvr_pkg::AccW'(lo_q) + RoundHalf;
  assign rnd  = RndW'(acc >>> qvr_pkg::FracDrop);
  assign fits = (rnd[RndW-1:VecW-1] == '0) || (rnd[RndW-1:VecW-1] == '1);

  always_comb begin
    if (fits) begin
      res_d = rnd[VecW-1:0];
    end else if (rnd[RndW-1]) begin
      res_d = {1'b1, {(VecW-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(VecW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a Q16.16 vector by a Q2.14 quaternion
// Vector part of conj(q) * (0, v) * q, rounded half up and saturated.
// ----------------------------------------------------------------------------
//
//  channel   | ports                  | handshake
//  ----------+------------------------+------------------------------------
//  request   | start, busy, req_i     | taken on a clock edge with start
//            |                        | high and busy low
//  result    | result_valid_o, rsp_o  | one-cycle strobe, no back-pressure
//
//  One request per clock; busy stays low. Each result passes through registers
//  for the quaternion products, matrix entries, split products against the
//  vector, row sums, then round and clamp. The depth is set by the 34 x 16 and
//  34 x 17 bit multipliers of the row units. Reset clears only the valid
//  pipeline; payload registers are not reset. The receiver cannot stall, so
//  nothing is ever held.
//
module quaternion_vector_rotate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  qvr_pkg::req_t req_i,
  output logic          result_valid_o,
  output qvr_pkg::rsp_t rsp_o
);

  localparam int unsigned ProdW = qvr_pkg::ProdW;
  localparam int unsigned MatW  = qvr_pkg::MatW;
  localparam int unsigned Depth = 5;

  typedef logic signed [ProdW-1:0] prod_t;

  // Valid bits, one per stage
  logic [Depth-1:0] vld_d, vld_q;

  // Stage 1 registers
  prod_t ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  qvr_pkg::vec_t vec1_q;

  // Stage 2 registers
  qvr_pkg::row_t row0_q, row1_q, row2_q;
  qvr_pkg::row_t row0_d, row1_d, row2_d;
  qvr_pkg::vec_t vec2_q;

  qvr_pkg::comp_t res0, res1, res2;

  // Every cycle can take a request
  assign busy = 1'b0;

  // Valid pipeline
  assign vld_d = {vld_q[Depth-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: the ten quaternion products
  always_ff @(posedge clk_i) begin
    if (start) begin
      ww_q     <= ProdW'(req_i.quat_w) * ProdW'(req_i.quat_w);
      xx_q     <= ProdW'(req_i.quat_x) * ProdW'(req_i.quat_x);
      yy_q     <= ProdW'(req_i.quat_y) * ProdW'(req_i.quat_y);
      zz_q     <= ProdW'(req_i.quat_z) * ProdW'(req_i.quat_z);
      xy_q     <= ProdW'(req_i.quat_x) * ProdW'(req_i.quat_y);
      wz_q     <= ProdW'(req_i.quat_w) * ProdW'(req_i.quat_z);
      xz_q     <= ProdW'(req_i.quat_x) * ProdW'(req_i.quat_z);
      wy_q     <= ProdW'(req_i.quat_w) * ProdW'(req_i.quat_y);
      yz_q     <= ProdW'(req_i.quat_y) * ProdW'(req_i.quat_z);
      wx_q     <= ProdW'(req_i.quat_w) * ProdW'(req_i.quat_x);
      vec1_q.x <= req_i.vec_x;
      vec1_q.y <= req_i.vec_y;
      vec1_q.z <= req_i.vec_z;
    end
  end

  // Stage 2: matrix entries in Q4.28
  always_comb begin
    row0_d.c0 = MatW'(ww_q) + MatW'(xx_q) - MatW'(yy_q) - MatW'(zz_q);
    row0_d.c1 = (MatW'(xy_q) + MatW'(wz_q)) <<< 1;
    row0_d.c2 = (MatW'(xz_q) - MatW'(wy_q)) <<< 1;
    row1_d.c0 = (MatW'(xy_q) - MatW'(wz_q)) <<< 1;
    row1_d.c1 = MatW'(ww_q) - MatW'(xx_q) + MatW'(yy_q) - MatW'(zz_q);
    row1_d.c2 = (MatW'(yz_q) + MatW'(wx_q)) <<< 1;
    row2_d.c0 = (MatW'(xz_q) + MatW'(wy_q)) <<< 1;
    row2_d.c1 = (MatW'(yz_q) - MatW'(wx_q)) <<< 1;
    row2_d.c2 = MatW'(ww_q) - MatW'(xx_q) - MatW'(yy_q) + MatW'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    row0_q <= row0_d;
    row1_q <= row1_d;
    row2_q <= row2_d;
    vec2_q <= vec1_q;
  end

  // Stages 3 to 5: one dot-product unit per output component
  qvr_row u_row0 (
    .clk_i (clk_i),
    .row_i (row0_q),
    .vec_i (vec2_q),
    .res_o (res0)
  );

  qvr_row u_row1 (
    .clk_i (clk_i),
    .row_i (row1_q),
    .vec_i (vec2_q),
    .res_o (res1)
  );

  qvr_row u_row2 (
    .clk_i (clk_i),
    .row_i (row2_q),
    .vec_i (vec2_q),
    .res_o (res2)
  );

  assign rsp_o.out_x    = res0;
  assign rsp_o.out_y    = res1;
  assign rsp_o.out_z    = res2;
  assign result_valid_o = vld_q[Depth-1];

endmodule

>>> dv/quaternion_vector_rotate_check.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_check: scoreboard for the quaternion vector rotator
// Watches the request and result channels. For every accepted request it
// works out the rotated vector exactly in wide integers, then rounds it half
// up to Q16.16 and clamps it. Results are matched in order, field by field.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  qvr_pkg::req_t req_i,
  input  logic          result_valid_i,
  input  qvr_pkg::rsp_t rsp_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for an exact three-term dot product in 2^-44 units
  typedef logic signed [95:0] wide_t;

  localparam wide_t HalfUlp = wide_t'(1) <<< 27;
  localparam wide_t CompMax = 96'sd2147483647;
  localparam wide_t CompMin = -96'sd2147483648;

  qvr_pkg::rsp_t rotations_due[$];

  // Round half toward plus infinity from 2^-44 units to Q16.16, then clamp
  function automatic qvr_pkg::comp_t round_clamp(input wide_t acc);
    wide_t r;
    r = (acc + HalfUlp) >>> 28;
    if (r > CompMax) r = CompMax;
    if (r < CompMin) r = CompMin;
    return qvr_pkg::comp_t'(r[31:0]);
  endfunction

  // Vector part of conj(q) * (0, v) * q, expanded as a 3x3 matrix product
  function automatic qvr_pkg::rsp_t rotate_vector(input qvr_pkg::req_t r);
    wide_t w, x, y, z, vx, vy, vz;
    wide_t ww, xx, yy, zz;
    wide_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    qvr_pkg::rsp_t res;
    w  = $signed(r.quat_w);
    x  = $signed(r.quat_x);
    y  = $signed(r.quat_y);
    z  = $signed(r.quat_z);
    vx = $signed(r.vec_x);
    vy = $signed(r.vec_y);
    vz = $signed(r.vec_z);
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    m00 = ww + xx - yy - zz;
    m01 = 2 * (x * y + w * z);
    m02 = 2 * (x * z - w * y);
    m10 = 2 * (x * y - w * z);
    m11 = ww - xx + yy - zz;
    m12 = 2 * (y * z + w * x);
    m20 = 2 * (x * z + w * y);
    m21 = 2 * (y * z - w * x);
    m22 = ww - xx - yy + zz;
    res.out_x = round_clamp(m00 * vx + m01 * vy + m02 * vz);
    res.out_y = round_clamp(m10 * vx + m11 * vy + m12 * vz);
    res.out_z = round_clamp(m20 * vx + m21 * vy + m22 * vz);
    return res;
  endfunction

  // One line per fault, and count it
  task automatic flag_fault(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  // Compare results against the oldest expectation, then log new requests
  always @(posedge clk_i) begin
    qvr_pkg::rsp_t want;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (rotations_due.size() == 0) begin
          flag_fault($sformatf("result (%0d, %0d, %0d) with no request outstanding",
                               rsp_i.out_x, rsp_i.out_y, rsp_i.out_z));
        end else begin
          want = rotations_due.pop_front();
          if (rsp_i.out_x !== want.out_x)
            flag_fault($sformatf("out_x got %0d, want %0d", rsp_i.out_x, want.out_x));
          if (rsp_i.out_y !== want.out_y)
            flag_fault($sformatf("out_y got %0d, want %0d", rsp_i.out_y, want.out_y));
          if (rsp_i.out_z !== want.out_z)
            flag_fault($sformatf("out_z got %0d, want %0d", rsp_i.out_z, want.out_z));
        end
      end
      if (start && !busy) rotations_due.push_back(rotate_vector(req_i));
      pending_o <= rotations_due.size();
    end
  end

endmodule

>>> dv/quaternion_vector_rotate_test.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_test: top-level testbench for the vector rotator
// Drives a directed set of corner requests, then three phases of random
// requests with differing idle rates. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int One       = 16384;       // 1.0 in Q2.14
  localparam int Cos45     = 11585;       // cos(pi/4) in Q2.14
  localparam int VecOne    = 65536;       // 1.0 in Q16.16
  localparam int PhaseLen  = 560;
  localparam int IdleLimit = 2000;
  localparam int DrainCyc  = 12;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  qvr_pkg::req_t req = '0;
  logic          result_valid;
  qvr_pkg::rsp_t rsp;
  int unsigned   mismatch_count;
  int unsigned   pending;
  int            idle_cycles;

  quaternion_vector_rotate dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .rsp_o          (rsp)
  );

  quaternion_vector_rotate_check checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .req_i            (req),
    .result_valid_i   (result_valid),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic qvr_pkg::req_t make_req(input int w, input int x, input int y,
                                             input int z, input int vx, input int vy,
                                             input int vz);
    qvr_pkg::req_t r;
    r.quat_w = w[15:0];
    r.quat_x = x[15:0];
    r.quat_y = y[15:0];
    r.quat_z = z[15:0];
    r.vec_x  = vx;
    r.vec_y  = vy;
    r.vec_z  = vz;
    return r;
  endfunction

  function automatic int rand_quat_comp();
    return int'($urandom_range(2 * One)) - One;
  endfunction

  function automatic int rand_vec_comp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return int'($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000;
    if (pick < 75) return int'($urandom());
    if (pick < 90) return int'($urandom_range(511)) - 256;
    return 0;
  endfunction

  // Mostly near-unit rotations, some arbitrary and some tiny quaternions
  function automatic qvr_pkg::req_t rand_request();
    int pick, w, x, y, z, sq;
    pick = $urandom_range(99);
    if (pick < 60) begin
      x  = int'($urandom_range(2 * 9459)) - 9459;
      y  = int'($urandom_range(2 * 9459)) - 9459;
      z  = int'($urandom_range(2 * 9459)) - 9459;
      sq = One * One - x * x - y * y - z * z;
      w  = int'($sqrt(real'(sq)));
      if (w > One) w = One;
      if ($urandom_range(1)) w = -w;
    end else if (pick < 85) begin
      w = rand_quat_comp();
      x = rand_quat_comp();
      y = rand_quat_comp();
      z = rand_quat_comp();
    end else begin
      w = int'($urandom_range(128)) - 64;
      x = int'($urandom_range(128)) - 64;
      y = int'($urandom_range(128)) - 64;
      z = int'($urandom_range(128)) - 64;
    end
    return make_req(w, x, y, z, rand_vec_comp(), rand_vec_comp(), rand_vec_comp());
  endfunction

  // Present one request and hold it until taken
  task automatic send_request(input qvr_pkg::req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle cycles after a request; each cycle idles at the given percentage
  task automatic maybe_idle(input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_phase(input int count, input int idle_pct);
    repeat (count) begin
      send_request(rand_request());
      maybe_idle(idle_pct);
    end
  endtask

  // Hold off until every outstanding request has produced its result
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Watchdog: too long with nothing accepted on either channel
  initial begin
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((start && !busy) || result_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("quaternion_vector_rotate_test failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    qvr_pkg::req_t dir[$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, extreme vectors, exact pass-through
    dir.push_back(make_req(One, 0, 0, 0, VecOne, 2 * VecOne, -3 * VecOne));
    dir.push_back(make_req(One, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    dir.push_back(make_req(One, 0, 0, 0, 32'h8000_0000, -1, 32'h7FFF_FFFF));
    dir.push_back(make_req(-One, 0, 0, 0, 32'h7FFF_FFFF, 1, -1));
    // zero vector gives zero whatever the quaternion
    dir.push_back(make_req(Cos45, Cos45, 0, 0, 0, 0, 0));
    dir.push_back(make_req(One, One, One, One, 0, 0, 0));
    // quarter and half turns about each axis
    dir.push_back(make_req(Cos45, Cos45, 0, 0, 0, VecOne, 0));
    dir.push_back(make_req(Cos45, 0, Cos45, 0, 0, 0, VecOne));
    dir.push_back(make_req(Cos45, 0, 0, Cos45, VecOne, 0, 0));
    dir.push_back(make_req(0, One, 0, 0, VecOne, VecOne, VecOne));
    dir.push_back(make_req(0, 0, One, 0, VecOne, -VecOne, VecOne));
    dir.push_back(make_req(0, 0, 0, -One, 3 * VecOne, 5 * VecOne, -7 * VecOne));
    // non-unit quaternions scale by |q|^2, with saturation
    dir.push_back(make_req(One, One, One, One, VecOne, VecOne, VecOne));
    dir.push_back(make_req(-One, -One, -One, -One, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF));
    dir.push_back(make_req(-One, One, -One, One, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000));
    dir.push_back(make_req(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    dir.push_back(make_req(One, -One, 0, 0, 1, -1, 32'h0000_7FFF));
    // tiny quaternion: rounding ties go toward plus infinity
    dir.push_back(make_req(1, 0, 0, 0, 32'h0800_0000, -32'sh0800_0000, 32'h1800_0000));
    dir.push_back(make_req(-1, 0, 0, 0, 32'h0800_0000, -32'sh0800_0000, 32'h07FF_FFFF));
    dir.push_back(make_req(0, 1, 1, 0, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_FFFF));
    foreach (dir[i]) send_request(dir[i]);

    // sender idles often, then pause for the pipeline to empty
    random_phase(PhaseLen, 32);
    wait_drained();
    random_phase(PhaseLen, 46);
    random_phase(PhaseLen, 0);

    // drain, then allow for any stray result
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCyc) @(posedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("quaternion_vector_rotate_test passed");
    end else begin
      $display("quaternion_vector_rotate_test failed");
    end
    $finish;
  end

endmodule

>>> quaternion_vector_rotate.f
rtl/core/qvr_pkg.sv
rtl/core/qvr_row.sv
rtl/core/quaternion_vector_rotate.sv
dv/quaternion_vector_rotate_check.sv
dv/quaternion_vector_rotate_test.sv
